// ----- src/ppc_pkg.sv -----
package ppc_pkg;

   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = COORD_BITS - 1;
   localparam int OUT_BITS   = COORD_BITS + 2;
   // internal width: covers anchor + span + offset and far edges with margin
   localparam int IW         = COORD_BITS + 4;
   localparam int NSTAGE     = 8;
   localparam int POS_BITS   = 4;
   localparam int FLAG_BITS  = 6;
   localparam int CSR_IDX_BITS = 2;

   // request payload layout, lowest bit first
   localparam int REQ_AX_LSB   = 0;
   localparam int REQ_AY_LSB   = REQ_AX_LSB + COORD_BITS;
   localparam int REQ_AW_LSB   = REQ_AY_LSB + COORD_BITS;
   localparam int REQ_AH_LSB   = REQ_AW_LSB + SIZE_BITS;
   localparam int REQ_PW_LSB   = REQ_AH_LSB + SIZE_BITS;
   localparam int REQ_PH_LSB   = REQ_PW_LSB + SIZE_BITS;
   localparam int REQ_OX_LSB   = REQ_PH_LSB + SIZE_BITS;
   localparam int REQ_OY_LSB   = REQ_OX_LSB + COORD_BITS;
   localparam int REQ_AP_LSB   = REQ_OY_LSB + COORD_BITS;
   localparam int REQ_GP_LSB   = REQ_AP_LSB + POS_BITS;
   localparam int REQ_FL_LSB   = REQ_GP_LSB + POS_BITS;
   localparam int REQ_RAW_BITS = REQ_FL_LSB + FLAG_BITS;
   localparam int REQ_BITS     = ((REQ_RAW_BITS + 7) / 8) * 8;

   // response payload layout, lowest bit first
   localparam int RSP_X_LSB    = 0;
   localparam int RSP_Y_LSB    = RSP_X_LSB + OUT_BITS;
   localparam int RSP_W_LSB    = RSP_Y_LSB + OUT_BITS;
   localparam int RSP_H_LSB    = RSP_W_LSB + SIZE_BITS;
   localparam int RSP_RAW_BITS = RSP_H_LSB + SIZE_BITS;
   localparam int RSP_BITS     = ((RSP_RAW_BITS + 7) / 8) * 8;

   // position codes
   localparam logic [POS_BITS-1:0] POS_NONE         = 4'd0;
   localparam logic [POS_BITS-1:0] POS_TOP          = 4'd1;
   localparam logic [POS_BITS-1:0] POS_BOTTOM       = 4'd2;
   localparam logic [POS_BITS-1:0] POS_LEFT         = 4'd3;
   localparam logic [POS_BITS-1:0] POS_RIGHT        = 4'd4;
   localparam logic [POS_BITS-1:0] POS_TOP_LEFT     = 4'd5;
   localparam logic [POS_BITS-1:0] POS_BOTTOM_LEFT  = 4'd6;
   localparam logic [POS_BITS-1:0] POS_TOP_RIGHT    = 4'd7;
   localparam logic [POS_BITS-1:0] POS_BOTTOM_RIGHT = 4'd8;

   // adjustment flag bit positions
   localparam int FLAG_SLIDE_X  = 0;
   localparam int FLAG_SLIDE_Y  = 1;
   localparam int FLAG_FLIP_X   = 2;
   localparam int FLAG_FLIP_Y   = 3;
   localparam int FLAG_RESIZE_X = 4;
   localparam int FLAG_RESIZE_Y = 5;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BOUND_LEFT   = 2'd0,
      CSR_BOUND_TOP    = 2'd1,
      CSR_BOUND_WIDTH  = 2'd2,
      CSR_BOUND_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_MID  = 2'd0,
      DIR_NEAR = 2'd1,
      DIR_FAR  = 2'd2
   } dir_type;

   typedef logic signed [IW-1:0] ival_type;

   typedef struct packed {
      logic [NSTAGE-1:0] en;
   } stage_ctl_type;

   function automatic dir_type dir_x(input logic [POS_BITS-1:0] code);
      dir_type d;
      case (code) inside
         POS_LEFT, POS_TOP_LEFT, POS_BOTTOM_LEFT:    d = DIR_NEAR;
         POS_RIGHT, POS_TOP_RIGHT, POS_BOTTOM_RIGHT: d = DIR_FAR;
         default:                                    d = DIR_MID;
      endcase
      return d;
   endfunction

   function automatic dir_type dir_y(input logic [POS_BITS-1:0] code);
      dir_type d;
      case (code) inside
         POS_TOP, POS_TOP_LEFT, POS_TOP_RIGHT:          d = DIR_NEAR;
         POS_BOTTOM, POS_BOTTOM_LEFT, POS_BOTTOM_RIGHT: d = DIR_FAR;
         default:                                       d = DIR_MID;
      endcase
      return d;
   endfunction

   function automatic dir_type dir_flip(input dir_type d);
      dir_type r;
      case (d)
         DIR_NEAR: r = DIR_FAR;
         DIR_FAR:  r = DIR_NEAR;
         default:  r = DIR_MID;
      endcase
      return r;
   endfunction

   function automatic ival_type sx(input logic [COORD_BITS-1:0] v);
      return ival_type'({{(IW-COORD_BITS){v[COORD_BITS-1]}}, v});
   endfunction

   function automatic ival_type zx(input logic [SIZE_BITS-1:0] v);
      return ival_type'({{(IW-SIZE_BITS){1'b0}}, v});
   endfunction

   function automatic ival_type max_i(input ival_type a, input ival_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic ival_type min_i(input ival_type a, input ival_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ----- src/ppc_flow.sv -----
module ppc_flow (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   out_ready,
   output logic                   in_ready,
   output logic                   out_valid,
   output ppc_pkg::stage_ctl_type ctl
);

   logic [ppc_pkg::NSTAGE-1:0] valid_ff;
   logic [ppc_pkg::NSTAGE-1:0] valid_in;
   logic [ppc_pkg::NSTAGE:0]   ready;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      ready[ppc_pkg::NSTAGE] = out_ready;
      for (int i = ppc_pkg::NSTAGE - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < ppc_pkg::NSTAGE; i++) begin
         valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.en    = ready[ppc_pkg::NSTAGE-1:0];
   assign in_ready  = ready[0];
   assign out_valid = valid_ff[ppc_pkg::NSTAGE-1];

endmodule

// ----- src/ppc_axis.sv -----
module ppc_axis (
   input  logic                                   clock,
   input  ppc_pkg::stage_ctl_type                 ctl,
   input  logic                                   cons,
   input  ppc_pkg::dir_type                       adir,
   input  ppc_pkg::dir_type                       gdir,
   input  logic signed [ppc_pkg::COORD_BITS-1:0]  near,
   input  logic        [ppc_pkg::SIZE_BITS-1:0]   span,
   input  logic        [ppc_pkg::SIZE_BITS-1:0]   extent,
   input  logic signed [ppc_pkg::COORD_BITS-1:0]  offset,
   input  logic signed [ppc_pkg::COORD_BITS-1:0]  bound_lo,
   input  logic        [ppc_pkg::SIZE_BITS-1:0]   bound_size,
   input  logic                                   flip,
   input  logic                                   slide,
   input  logic                                   resize,
   output logic signed [ppc_pkg::OUT_BITS-1:0]    out_near,
   output logic        [ppc_pkg::SIZE_BITS-1:0]   out_extent
);

   localparam int SB = ppc_pkg::SIZE_BITS;

   function automatic ppc_pkg::ival_type pick(input ppc_pkg::dir_type d,
                                              input ppc_pkg::ival_type vn,
                                              input ppc_pkg::ival_type vf,
                                              input ppc_pkg::ival_type vm);
      ppc_pkg::ival_type r;
      case (d)
         ppc_pkg::DIR_NEAR: r = vn;
         ppc_pkg::DIR_FAR:  r = vf;
         default:           r = vm;
      endcase
      return r;
   endfunction

   // bounds, refreshed every cycle from the static configuration
   ppc_pkg::ival_type lo_ff, hi_ff;

   always_ff @(posedge clock) begin
      lo_ff <= ppc_pkg::sx(bound_lo);
      hi_ff <= ppc_pkg::sx(bound_lo) + ppc_pkg::zx(bound_size);
   end

   // stage 1: anchor point and gravity term, direct and mirrored
   ppc_pkg::ival_type a1_in, af1_in, g1_in, gf1_in, a_near, a_far, a_mid;
   ppc_pkg::ival_type g_near, g_mid;
   ppc_pkg::ival_type a1_ff, af1_ff, g1_ff, gf1_ff, off1_ff;
   logic [SB-1:0]     ext1_ff;
   logic [2:0]        flg1_ff;

   always_comb begin
      a_near = ppc_pkg::sx(near);
      a_far  = ppc_pkg::sx(near) + ppc_pkg::zx(span);
      a_mid  = ppc_pkg::sx(near) + ppc_pkg::zx(span >> 1);
      g_near = -ppc_pkg::zx(extent);
      g_mid  = -ppc_pkg::zx(extent >> 1);
      a1_in  = pick(adir, a_near, a_far, a_mid);
      af1_in = pick(ppc_pkg::dir_flip(adir), a_near, a_far, a_mid);
      g1_in  = pick(gdir, g_near, '0, g_mid);
      gf1_in = pick(ppc_pkg::dir_flip(gdir), g_near, '0, g_mid);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         a1_ff   <= a1_in;
         af1_ff  <= af1_in;
         g1_ff   <= g1_in;
         gf1_ff  <= gf1_in;
         off1_ff <= ppc_pkg::sx(offset);
         ext1_ff <= extent;
         flg1_ff <= {resize, slide, flip};
      end
   end

   // stage 2: candidate near edges
   ppc_pkg::ival_type x2_ff, xf2_ff;
   logic [SB-1:0]     ext2_ff;
   logic [2:0]        flg2_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         x2_ff   <= a1_ff + g1_ff + off1_ff;
         xf2_ff  <= af1_ff + gf1_ff + off1_ff;
         ext2_ff <= ext1_ff;
         flg2_ff <= flg1_ff;
      end
   end

   // stage 3: far edges and low-bound checks
   ppc_pkg::ival_type x3_ff, xf3_ff, xe3_ff, xfe3_ff;
   logic              xlo3_ff, xflo3_ff;
   logic [SB-1:0]     ext3_ff;
   logic [2:0]        flg3_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         x3_ff    <= x2_ff;
         xf3_ff   <= xf2_ff;
         xe3_ff   <= x2_ff + ppc_pkg::zx(ext2_ff);
         xfe3_ff  <= xf2_ff + ppc_pkg::zx(ext2_ff);
         xlo3_ff  <= x2_ff >= lo_ff;
         xflo3_ff <= xf2_ff >= lo_ff;
         ext3_ff  <= ext2_ff;
         flg3_ff  <= flg2_ff;
      end
   end

   // stage 4: fit flags and clipped overlap ends
   ppc_pkg::ival_type x4_ff, xf4_ff, xe4_ff, xfe4_ff;
   ppc_pkg::ival_type cl4_ff, ch4_ff, clf4_ff, chf4_ff;
   logic              fit4_ff, fitf4_ff;
   logic [SB-1:0]     ext4_ff;
   logic [2:0]        flg4_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         x4_ff    <= x3_ff;
         xf4_ff   <= xf3_ff;
         xe4_ff   <= xe3_ff;
         xfe4_ff  <= xfe3_ff;
         // no bounds: treat as fitting, which skips every adjustment
         fit4_ff  <= !cons || (xlo3_ff && (xe3_ff <= hi_ff));
         fitf4_ff <= xflo3_ff && (xfe3_ff <= hi_ff);
         cl4_ff   <= ppc_pkg::max_i(x3_ff, lo_ff);
         ch4_ff   <= ppc_pkg::min_i(xe3_ff, hi_ff);
         clf4_ff  <= ppc_pkg::max_i(xf3_ff, lo_ff);
         chf4_ff  <= ppc_pkg::min_i(xfe3_ff, hi_ff);
         ext4_ff  <= ext3_ff;
         flg4_ff  <= flg3_ff;
      end
   end

   // stage 5: flip decision
   ppc_pkg::ival_type d0, df, near5_in, end5_in;
   logic              take_f, fit5_in;
   ppc_pkg::ival_type near5_ff, end5_ff;
   logic              fit5_ff;
   logic [SB-1:0]     ext5_ff;
   logic [1:0]        flg5_ff;

   always_comb begin
      d0       = ch4_ff - cl4_ff;
      df       = chf4_ff - clf4_ff;
      take_f   = !fit4_ff && flg4_ff[0] && (fitf4_ff || ((df > 0) && (df > d0)));
      near5_in = take_f ? xf4_ff : x4_ff;
      end5_in  = take_f ? xfe4_ff : xe4_ff;
      fit5_in  = fit4_ff || (take_f && fitf4_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[4]) begin
         near5_ff <= near5_in;
         end5_ff  <= end5_in;
         fit5_ff  <= fit5_in;
         ext5_ff  <= ext4_ff;
         flg5_ff  <= flg4_ff[2:1];
      end
   end

   // stage 6: slide
   ppc_pkg::ival_type near6_in, near6_ff;
   logic              done6_ff, rsz6_ff;
   logic [SB-1:0]     ext6_ff;

   always_comb begin
      near6_in = near5_ff;
      if (!fit5_ff && flg5_ff[0]) begin
         if (end5_ff > hi_ff) begin
            near6_in = ppc_pkg::max_i(lo_ff, hi_ff - ppc_pkg::zx(ext5_ff));
         end else if (near5_ff < lo_ff) begin
            near6_in = lo_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[5]) begin
         near6_ff <= near6_in;
         done6_ff <= fit5_ff;
         rsz6_ff  <= flg5_ff[1];
         ext6_ff  <= ext5_ff;
      end
   end

   // stage 7: refit after slide
   ppc_pkg::ival_type near7_ff, end7_ff, end7_in;
   logic              fit7_ff, rsz7_ff;
   logic [SB-1:0]     ext7_ff;

   assign end7_in = near6_ff + ppc_pkg::zx(ext6_ff);

   always_ff @(posedge clock) begin
      if (ctl.en[6]) begin
         near7_ff <= near6_ff;
         end7_ff  <= end7_in;
         fit7_ff  <= done6_ff || ((near6_ff >= lo_ff) && (end7_in <= hi_ff));
         rsz7_ff  <= rsz6_ff;
         ext7_ff  <= ext6_ff;
      end
   end

   // stage 8: resize by clipping, output register
   ppc_pkg::ival_type clip_lo, clip_d, near8_in, near8_ff;
   logic [SB-1:0]     ext8_in, ext8_ff;

   always_comb begin
      clip_lo  = ppc_pkg::max_i(near7_ff, lo_ff);
      clip_d   = ppc_pkg::min_i(end7_ff, hi_ff) - clip_lo;
      near8_in = near7_ff;
      ext8_in  = ext7_ff;
      if (!fit7_ff && rsz7_ff) begin
         near8_in = clip_lo;
         ext8_in  = (clip_d > 0) ? clip_d[SB-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[7]) begin
         near8_ff <= near8_in;
         ext8_ff  <= ext8_in;
      end
   end

   assign out_near   = near8_ff[ppc_pkg::OUT_BITS-1:0];
   assign out_extent = ext8_ff;

endmodule

// ----- src/popup_placement_constrain.sv -----
// Channel  | Direction | Handshake         | Payload
// req_     | in        | tvalid / tready   | tdata: popup request
// rsp_     | out       | tvalid / tready   | tdata: placed rectangle
// csr_     | in        | we (no wait)      | index, wdata: work area bounds
//
// One transaction enters per cycle unless a stall on rsp_ holds a full pipeline;
// each result passes through the eight register stages of the per-axis placement pipeline.
// Reset clears the stage valid bits and the bound registers (empty bounds).
// A stall on rsp_ holds only the stages that are full: bubbles close up, so
// req_tready stays high while any stage ahead is empty.
module popup_placement_constrain (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // anchor_x, anchor_y, anchor_width, anchor_height, popup_width,
   // popup_height, offset_x, offset_y, anchor_point, gravity_point,
   // adjust_flags, zero pad
   input  logic [ppc_pkg::REQ_BITS-1:0]        req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_x, out_y, out_width, out_height, zero pad
   output logic [ppc_pkg::RSP_BITS-1:0]        rsp_tdata,
   input  logic                                csr_we,
   input  logic [ppc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ppc_pkg::COORD_BITS-1:0]      csr_wdata
);

   localparam int CB = ppc_pkg::COORD_BITS;
   localparam int SB = ppc_pkg::SIZE_BITS;
   localparam int PB = ppc_pkg::POS_BITS;

   // work area bounds
   logic signed [CB-1:0] bound_left_ff, bound_top_ff;
   logic [SB-1:0]        bound_width_ff, bound_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_left_ff   <= '0;
         bound_top_ff    <= '0;
         bound_width_ff  <= '0;
         bound_height_ff <= '0;
      end else if (csr_we) begin
         unique case (ppc_pkg::csr_index_type'(csr_index))
            ppc_pkg::CSR_BOUND_LEFT:   bound_left_ff   <= csr_wdata;
            ppc_pkg::CSR_BOUND_TOP:    bound_top_ff    <= csr_wdata;
            ppc_pkg::CSR_BOUND_WIDTH:  bound_width_ff  <= csr_wdata[SB-1:0];
            ppc_pkg::CSR_BOUND_HEIGHT: bound_height_ff <= csr_wdata[SB-1:0];
            default: ;
         endcase
      end
   end

   // an empty work area disables every adjustment on both axes
   logic cons;
   assign cons = (bound_width_ff != '0) && (bound_height_ff != '0);

   // unpack the request
   logic signed [CB-1:0] anchor_x, anchor_y, offset_x, offset_y;
   logic [SB-1:0]        anchor_width, anchor_height, popup_width, popup_height;
   logic [PB-1:0]        anchor_point, gravity_point;
   logic [ppc_pkg::FLAG_BITS-1:0] adjust_flags;

   assign anchor_x      = req_tdata[ppc_pkg::REQ_AX_LSB +: CB];
   assign anchor_y      = req_tdata[ppc_pkg::REQ_AY_LSB +: CB];
   assign anchor_width  = req_tdata[ppc_pkg::REQ_AW_LSB +: SB];
   assign anchor_height = req_tdata[ppc_pkg::REQ_AH_LSB +: SB];
   assign popup_width   = req_tdata[ppc_pkg::REQ_PW_LSB +: SB];
   assign popup_height  = req_tdata[ppc_pkg::REQ_PH_LSB +: SB];
   assign offset_x      = req_tdata[ppc_pkg::REQ_OX_LSB +: CB];
   assign offset_y      = req_tdata[ppc_pkg::REQ_OY_LSB +: CB];
   assign anchor_point  = req_tdata[ppc_pkg::REQ_AP_LSB +: PB];
   assign gravity_point = req_tdata[ppc_pkg::REQ_GP_LSB +: PB];
   assign adjust_flags  = req_tdata[ppc_pkg::REQ_FL_LSB +: ppc_pkg::FLAG_BITS];

   // stage enables and valid tracking
   ppc_pkg::stage_ctl_type ctl;

   ppc_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .ctl       (ctl)
   );

   logic signed [ppc_pkg::OUT_BITS-1:0] out_x, out_y;
   logic [SB-1:0]                       out_width, out_height;

   // horizontal axis: left/right part of the position codes
   ppc_axis u_axis_x (
      .clock      (clock),
      .ctl        (ctl),
      .cons       (cons),
      .adir       (ppc_pkg::dir_x(anchor_point)),
      .gdir       (ppc_pkg::dir_x(gravity_point)),
      .near       (anchor_x),
      .span       (anchor_width),
      .extent     (popup_width),
      .offset     (offset_x),
      .bound_lo   (bound_left_ff),
      .bound_size (bound_width_ff),
      .flip       (adjust_flags[ppc_pkg::FLAG_FLIP_X]),
      .slide      (adjust_flags[ppc_pkg::FLAG_SLIDE_X]),
      .resize     (adjust_flags[ppc_pkg::FLAG_RESIZE_X]),
      .out_near   (out_x),
      .out_extent (out_width)
   );

   // vertical axis: top/bottom part of the position codes
   ppc_axis u_axis_y (
      .clock      (clock),
      .ctl        (ctl),
      .cons       (cons),
      .adir       (ppc_pkg::dir_y(anchor_point)),
      .gdir       (ppc_pkg::dir_y(gravity_point)),
      .near       (anchor_y),
      .span       (anchor_height),
      .extent     (popup_height),
      .offset     (offset_y),
      .bound_lo   (bound_top_ff),
      .bound_size (bound_height_ff),
      .flip       (adjust_flags[ppc_pkg::FLAG_FLIP_Y]),
      .slide      (adjust_flags[ppc_pkg::FLAG_SLIDE_Y]),
      .resize     (adjust_flags[ppc_pkg::FLAG_RESIZE_Y]),
      .out_near   (out_y),
      .out_extent (out_height)
   );

   // pack the result, zero pad on top
   assign rsp_tdata = {{(ppc_pkg::RSP_BITS - ppc_pkg::RSP_RAW_BITS){1'b0}},
                       out_height, out_width, out_y, out_x};

   // a ready sink means every stage can move, so the input must be open
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input blocked while result side is ready");

   // an empty output stage lets the whole pipeline advance
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output stage");

   // reset flushes every transaction in flight
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
